[design/fetp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fetp_pkg
// shared types, register codes and helpers for the escape-time pixel unit
// ----------------------------------------------------------------------------
package fetp_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_JULIA_MODE   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_REAL  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_IMAG  = 3'd2;
  localparam logic [2:0] REG_STEP_SIZE    = 3'd3;
  localparam logic [2:0] REG_ITER_LIMIT   = 3'd4;
  localparam logic [2:0] REG_CONST_REAL   = 3'd5;
  localparam logic [2:0] REG_CONST_IMAG   = 3'd6;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned SCALED_W  = INDEX_W + STEP_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic signed [63:0] S32_MAX_W = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN_W = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic                        julia_mode;
    logic signed [COORD_W-1:0]   origin_real;
    logic signed [COORD_W-1:0]   origin_imag;
    logic        [STEP_W-1:0]    step_size;
    logic        [LIMIT_W-1:0]   iteration_limit;
    logic signed [COORD_W-1:0]   const_real;
    logic signed [COORD_W-1:0]   const_imag;
  } cfg_t;

  // pixel point handed from front end to iteration core
  typedef struct packed {
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
  } point_t;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_MUL,
    CORE_UPDATE,
    CORE_DONE
  } core_state_e;

  // clip a wide signed value into the 32-bit coordinate range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > S32_MAX_W) begin
      r = S32_MAX_W[COORD_W-1:0];
    end else if (v < S32_MIN_W) begin
      r = S32_MIN_W[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/fetp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fetp_front
// takes a pixel word, clamps the indexes and maps them to a complex point
// ----------------------------------------------------------------------------
module fetp_front import fetp_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [2*INDEX_W-1:0]  s_tdata_i,   // column [11:0], row [23:12]
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output point_t                q_data_o
);

  front_state_e state_q, state_d;

  logic [INDEX_W-1:0]  col, row;
  logic [SCALED_W-1:0] prod_col_q, prod_row_q;
  logic signed [63:0]  sum_re, sum_im;
  logic                accept;

  // indexes past the image edge land on the last column or row
  always_comb begin
    col = s_tdata_i[INDEX_W-1:0];
    row = s_tdata_i[2*INDEX_W-1:INDEX_W];
    if (32'(col) >= 32'(MAX_DIM)) begin
      col = INDEX_W'(MAX_DIM - 1);
    end
    if (32'(row) >= 32'(MAX_DIM)) begin
      row = INDEX_W'(MAX_DIM - 1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FRONT_IDLE: if (s_tvalid_i) state_d = FRONT_PUSH;
      FRONT_PUSH: if (!q_full_i)  state_d = FRONT_IDLE;
      default:    state_d = FRONT_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o = 1'b0;
    q_push_o   = 1'b0;
    unique case (state_q)
      FRONT_IDLE: s_tready_o = 1'b1;
      FRONT_PUSH: q_push_o   = !q_full_i;
      default: ;
    endcase
  end

  assign accept = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_col_q <= SCALED_W'(col) * SCALED_W'(cfg_i.step_size);
      prod_row_q <= SCALED_W'(row) * SCALED_W'(cfg_i.step_size);
    end
  end

  assign sum_re = 64'(cfg_i.origin_real) + $signed({{(64-SCALED_W){1'b0}}, prod_col_q});
  assign sum_im = 64'(cfg_i.origin_imag) + $signed({{(64-SCALED_W){1'b0}}, prod_row_q});

  assign q_data_o.re = sat32(sum_re);
  assign q_data_o.im = sat32(sum_im);

endmodule

[design/fetp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fetp_queue
// short fifo of pixel points between the front end and the core
// ----------------------------------------------------------------------------
module fetp_queue import fetp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  point_t data_i,
  output logic   full_o,
  output logic   valid_o,
  output point_t data_o,
  input  logic   pop_i
);

  point_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

[design/fetp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fetp_core
// iterates z = z*z + c for one point and holds the finished count
// ----------------------------------------------------------------------------
module fetp_core import fetp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               pt_valid_i,
  input  point_t             pt_i,
  output logic               pt_pop_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [COUNT_W-1:0] m_tdata_o
);

  localparam logic [64:0] BOUND = 65'(4) << FRAC_BITS;

  core_state_e state_q, state_d;

  logic signed [COORD_W-1:0] zr_q, zi_q, cr_q, ci_q;
  logic        [LIMIT_W-1:0] cnt_q;
  logic        [63:0]        prod_rr_q, prod_ii_q;
  logic signed [63:0]        prod_ri_q;
  logic                      out_valid_q;
  logic        [COUNT_W-1:0] out_data_q;

  logic        [63:0]        r2, i2;
  logic        [64:0]        mag;
  logic                      escape, at_limit;
  logic signed [63:0]        nr, ni;
  logic                      mul_en, upd_en, out_load;

  assign r2       = prod_rr_q >> FRAC_BITS;
  assign i2       = prod_ii_q >> FRAC_BITS;
  assign mag      = {1'b0, r2} + {1'b0, i2};
  assign escape   = (mag >= BOUND);
  assign at_limit = (cnt_q == cfg_i.iteration_limit);
  assign nr       = $signed(r2) - $signed(i2) + 64'(cr_q);
  assign ni       = (prod_ri_q >>> (FRAC_BITS - 1)) + 64'(ci_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CORE_IDLE:   if (pt_valid_i) state_d = CORE_MUL;
      CORE_MUL:    state_d = at_limit ? CORE_DONE : CORE_UPDATE;
      CORE_UPDATE: state_d = escape ? CORE_DONE : CORE_MUL;
      CORE_DONE:   if (!out_valid_q || m_tready_i) state_d = CORE_IDLE;
      default:     state_d = CORE_IDLE;
    endcase
  end

  always_comb begin
    pt_pop_o = 1'b0;
    mul_en   = 1'b0;
    upd_en   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      CORE_IDLE:   pt_pop_o = pt_valid_i;
      CORE_MUL:    mul_en   = !at_limit;
      CORE_UPDATE: upd_en   = !escape;
      CORE_DONE:   out_load = !out_valid_q || m_tready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CORE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_pop_o) begin
      cnt_q <= '0;
      if (cfg_i.julia_mode) begin
        zr_q <= pt_i.re;
        zi_q <= pt_i.im;
        cr_q <= cfg_i.const_real;
        ci_q <= cfg_i.const_imag;
      end else begin
        zr_q <= '0;
        zi_q <= '0;
        cr_q <= pt_i.re;
        ci_q <= pt_i.im;
      end
    end
    if (mul_en) begin
      prod_rr_q <= 64'(zr_q) * 64'(zr_q);
      prod_ii_q <= 64'(zi_q) * 64'(zi_q);
      prod_ri_q <= 64'(zr_q) * 64'(zi_q);
    end
    if (upd_en) begin
      zr_q  <= sat32(nr);
      zi_q  <= sat32(ni);
      cnt_q <= cnt_q + 1'b1;
    end
    if (out_load) begin
      out_data_q <= cnt_q[COUNT_W-1:0];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

[design/fractal_escape_time_pixel_unit.sv]
`timescale 1ns / 1ps
// the core pops a point, then multiplies and updates per step until the count reaches
// the iteration limit or the point escapes, then loads the count into the output register
// once that register is free; it takes the next point only after that load, while the
// front end maps the next pixel and the queue holds two
// reset: asynchronous active-low rst_ni clears all handshake state and loads the
// register defaults (mandelbrot mode, origin 0, step 268435, limit 255)
// ----------------------------------------------------------------------------
// fractal_escape_time_pixel_unit
// escape-time mandelbrot/julia pixel engine with apb register port
// ----------------------------------------------------------------------------
module fractal_escape_time_pixel_unit import fetp_pkg::*; #(
  parameter int unsigned MAX_DIM   = 4096,
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // apb register port
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [4:0]           paddr_i,
  input  logic [31:0]          pwdata_i,
  output logic [31:0]          prdata_o,
  output logic                 pready_o,
  // pixel words in
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [2*INDEX_W-1:0] s_tdata_i,   // column [11:0], row [23:12]
  // escape counts out
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [COUNT_W-1:0]   m_tdata_o    // escape_count [7:0]
);

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       reg_wr;

  logic       q_full, q_push, q_valid, q_pop;
  point_t     q_wdata, q_rdata;

  // registers sit on word addresses, one per 4 bytes
  assign reg_idx  = paddr_i[4:2];
  assign pready_o = 1'b1;
  assign reg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.julia_mode      <= 1'b0;
      cfg_q.origin_real     <= '0;
      cfg_q.origin_imag     <= '0;
      cfg_q.step_size       <= STEP_W'(268435);
      cfg_q.iteration_limit <= LIMIT_W'(255);
      cfg_q.const_real      <= '0;
      cfg_q.const_imag      <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_JULIA_MODE:  cfg_q.julia_mode      <= pwdata_i[0];
        REG_ORIGIN_REAL: cfg_q.origin_real     <= pwdata_i;
        REG_ORIGIN_IMAG: cfg_q.origin_imag     <= pwdata_i;
        REG_STEP_SIZE:   cfg_q.step_size       <= pwdata_i[STEP_W-1:0];
        REG_ITER_LIMIT:  cfg_q.iteration_limit <= pwdata_i[LIMIT_W-1:0];
        REG_CONST_REAL:  cfg_q.const_real      <= pwdata_i;
        REG_CONST_IMAG:  cfg_q.const_imag      <= pwdata_i;
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // read-back of the register file, zero outside the map
  always_comb begin
    unique case (reg_idx)
      REG_JULIA_MODE:  prdata_o = {31'b0, cfg_q.julia_mode};
      REG_ORIGIN_REAL: prdata_o = cfg_q.origin_real;
      REG_ORIGIN_IMAG: prdata_o = cfg_q.origin_imag;
      REG_STEP_SIZE:   prdata_o = {1'b0, cfg_q.step_size};
      REG_ITER_LIMIT:  prdata_o = {16'b0, cfg_q.iteration_limit};
      REG_CONST_REAL:  prdata_o = cfg_q.const_real;
      REG_CONST_IMAG:  prdata_o = cfg_q.const_imag;
      default:         prdata_o = '0;
    endcase
  end

  // front end: clamp indexes, scale by step, add origin, saturate
  fetp_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  // decouples point mapping from the iteration loop
  fetp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .pop_i   (q_pop)
  );

  // back end: iteration loop plus output register
  fetp_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pt_valid_i (q_valid),
    .pt_i       (q_rdata),
    .pt_pop_o   (q_pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule

[tb/tb_fractal_escape_time_pixel_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fractal_escape_time_pixel_unit
// self-checking bench for the escape-time pixel unit: a directed table of
// corner pixels and register settings, then randomized register settings with
// random pixel words, each escape count checked against a listed count or a local model
// ----------------------------------------------------------------------------
module tb_fractal_escape_time_pixel_unit;
  import fetp_pkg::*;

  // run control
  localparam int          CYCLE_LIMIT  = 3_000_000;
  localparam int          NUM_PHASES   = 27;
  localparam int          PHASE_WORDS  = 56;
  localparam int          DEEP_WORDS   = 12;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 600;
  localparam int unsigned IDLE_PCT     = 28;

  // unmapped register slot, writes there must be dropped
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // q4.28 helpers
  localparam int     FRAC  = 28;
  localparam longint BOUND = 64'sd4 <<< FRAC;
  localparam int     ONE   = 268435456;
  localparam int     TWO   = 536870912;
  localparam int     THREE = 805306368;
  localparam int     WIN_RE = -590558003;   // -2.2
  localparam int     WIN_IM = -429496730;   // -1.6
  localparam int     JC_RE  = -214748365;   // -0.8
  localparam int     JC_IM  = 41875931;     // 0.156
  localparam int     NEAR_TWO = 510027366;  // 1.9

  localparam cfg_t RESET_CFG = '{
    julia_mode: 1'b0, origin_real: '0, origin_imag: '0, step_size: 31'd268435,
    iteration_limit: 16'd255, const_real: '0, const_imag: '0
  };

  // one directed pixel, optionally preceded by a register setting
  typedef struct {
    bit          new_cfg;
    cfg_t        cfg;
    logic [11:0] px_col;
    logic [11:0] px_row;
    bit          known;
    logic [7:0]  count;
  } pixel_case_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  logic        s_tvalid = 1'b0;
  logic        s_tready_o;
  logic [23:0] s_tdata = '0;    // column [11:0], row [23:12]
  logic        m_tvalid_o;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata_o;       // escape_count [7:0]

  // register image the bench believes the block holds
  cfg_t        shadow = RESET_CFG;
  logic [7:0]  pending_counts[$];
  pixel_case_t directed[$];
  cfg_t        last_case_cfg = RESET_CFG;

  int          mismatches = 0;
  int          sent_pixels = 0;
  int          checked_counts = 0;
  int          settings_cnt = 0;
  int          cycles = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  bit          calm = 1'b0;     // no idling on either side while set
  logic [7:0]  want;

  always #4 clk_i = ~clk_i;

  fractal_escape_time_pixel_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata_o),
    .pready_o   (pready_o),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata_o)
  );

  // clip to the signed 32-bit coordinate range
  function automatic longint clip_coord(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // escape count of one pixel under the current register image
  function automatic logic [7:0] escape_steps(input logic [11:0] col,
                                              input logic [11:0] row);
    longint      pr, pi, zr, zi, cr, ci, re2, im2;
    int unsigned steps;
    pr = clip_coord(longint'(shadow.origin_real) +
                    longint'(col) * longint'(shadow.step_size));
    pi = clip_coord(longint'(shadow.origin_imag) +
                    longint'(row) * longint'(shadow.step_size));
    if (shadow.julia_mode) begin
      zr = pr;
      zi = pi;
      cr = longint'(shadow.const_real);
      ci = longint'(shadow.const_imag);
    end else begin
      zr = 0;
      zi = 0;
      cr = pr;
      ci = pi;
    end
    steps = 0;
    while (steps < shadow.iteration_limit) begin
      re2 = (zr * zr) >>> FRAC;
      im2 = (zi * zi) >>> FRAC;
      if (re2 + im2 >= BOUND) break;
      // arithmetic shift floors, which is what the datapath does for 2*x*y
      zi = clip_coord(((zr * zi) >>> (FRAC - 1)) + ci);
      zr = clip_coord(re2 - im2 + cr);
      steps++;
    end
    return steps[7:0];
  endfunction

  // value a register reads back as
  function automatic logic [31:0] reg_image(input cfg_t c, input logic [2:0] idx);
    case (idx)
      REG_JULIA_MODE:  return {31'b0, c.julia_mode};
      REG_ORIGIN_REAL: return c.origin_real;
      REG_ORIGIN_IMAG: return c.origin_imag;
      REG_STEP_SIZE:   return {1'b0, c.step_size};
      REG_ITER_LIMIT:  return {16'b0, c.iteration_limit};
      REG_CONST_REAL:  return c.const_real;
      REG_CONST_IMAG:  return c.const_imag;
      default:         return '0;
    endcase
  endfunction

  function automatic cfg_t random_setting(input bit deep);
    cfg_t c;
    c.julia_mode = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      // anything goes, mostly instant escapes and saturation
      c.origin_real = $urandom();
      c.origin_imag = $urandom();
      c.step_size   = 31'($urandom());
      c.const_real  = $urandom();
      c.const_imag  = $urandom();
    end else begin
      // a window near the set, where the counts get interesting
      c.origin_real = WIN_RE + $urandom_range(0, ONE);
      c.origin_imag = WIN_IM + $urandom_range(0, ONE);
      c.step_size   = 31'($urandom_range(20000, 260000));
      c.const_real  = $urandom_range(0, TWO) - ONE;
      c.const_imag  = $urandom_range(0, TWO) - ONE;
    end
    if (deep) begin
      c.iteration_limit = 16'($urandom_range(200, 700));
    end else if ($urandom_range(0, 7) == 0) begin
      c.iteration_limit = 16'($urandom_range(0, 3));
    end else begin
      c.iteration_limit = 16'($urandom_range(4, 100));
    end
    return c;
  endfunction

  function automatic logic [11:0] random_index();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    end
    return 12'($urandom());
  endfunction

  task automatic add_case(input cfg_t c, input logic [11:0] col, input logic [11:0] row,
                          input bit known, input logic [7:0] count);
    pixel_case_t pc;
    pc.new_cfg    = (c != last_case_cfg);
    pc.cfg        = c;
    pc.px_col     = col;
    pc.px_row     = row;
    pc.known      = known;
    pc.count      = count;
    last_case_cfg = c;
    directed.push_back(pc);
  endtask

  // one apb transfer: setup phase, then access until pready
  task automatic apb_access(input bit is_write, input logic [2:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    rdata = prdata_o;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic verify_regs();
    logic [31:0] got;
    for (int i = REG_JULIA_MODE; i <= REG_CONST_IMAG; i++) begin
      apb_access(1'b0, 3'(i), '0, got);
      if (got !== reg_image(shadow, 3'(i))) begin
        $display("%0t: register %0d reads %h, expected %h", $realtime, i, got,
                 reg_image(shadow, 3'(i)));
        mismatches++;
      end
    end
  endtask

  task automatic program_regs(input cfg_t c);
    logic [31:0] unused_rd;
    for (int i = REG_JULIA_MODE; i <= REG_CONST_IMAG; i++) begin
      apb_access(1'b1, 3'(i), reg_image(c, 3'(i)), unused_rd);
    end
    shadow = c;
    // unmapped slot: the readback and the next pixels show nothing moved
    apb_access(1'b1, REG_UNUSED, $urandom(), unused_rd);
    settings_cnt++;
    verify_regs();
  endtask

  // stop offering and let every count come home, then let the core settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // offer one pixel word; valid stays high after acceptance unless a gap follows
  task automatic offer_pixel(input logic [11:0] col, input logic [11:0] row,
                             input bit known, input logic [7:0] count);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {row, col};
    do @(posedge clk_i); while (!s_tready_o);
    pending_counts.push_back(known ? count : escape_steps(col, row));
    sent_pixels++;
  endtask

  // receiver: random backpressure, a long hold-off on request, and the checker
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (m_tvalid_o && m_tready) begin
        if (pending_counts.size() == 0) begin
          $display("%0t: escape count %0d arrived with nothing pending", $realtime,
                   m_tdata_o);
          mismatches++;
        end else begin
          want = pending_counts.pop_front();
          checked_counts++;
          if (m_tdata_o !== want) begin
            $display("%0t: escape_count mismatch, expected %0d, got %0d", $realtime,
                     want, m_tdata_o);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req > 0) begin
        hold_left = hold_req - 1;
        hold_req  = 0;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d counts still pending", $realtime,
               cycles, pending_counts.size());
      $display("fractal_escape_time_pixel_unit test failed");
      $finish;
    end
  end

  initial begin
    cfg_t        zero_lim, zero_step, julia_out, julia_in, sat_mand, sat_julia, long_lim;
    cfg_t        next_cfg;
    bit          deep;
    int          n_words;
    int          n_directed;

    zero_lim                  = RESET_CFG;
    zero_lim.iteration_limit  = '0;
    // every pixel lands on the origin, c = 0 never escapes, 300 wraps to 44
    zero_step                 = RESET_CFG;
    zero_step.step_size       = '0;
    zero_step.iteration_limit = 16'd300;
    // julia start already outside the radius
    julia_out                 = RESET_CFG;
    julia_out.julia_mode      = 1'b1;
    julia_out.origin_real     = THREE;
    julia_out.step_size       = 31'd1;
    julia_out.const_real      = JC_RE;
    julia_out.const_imag      = JC_IM;
    julia_in                  = julia_out;
    julia_in.origin_real      = -TWO;
    julia_in.origin_imag      = -TWO;
    julia_in.step_size        = 31'd268435;
    // extreme origins and largest pitch, the far pixel point saturates
    sat_mand                  = RESET_CFG;
    sat_mand.origin_real      = 32'h7FFF_FFFF;
    sat_mand.origin_imag      = 32'h8000_0000;
    sat_mand.step_size        = 31'h7FFF_FFFF;
    // first iterate overflows through the constant
    sat_julia                 = RESET_CFG;
    sat_julia.julia_mode      = 1'b1;
    sat_julia.origin_real     = NEAR_TWO;
    sat_julia.step_size       = 31'd1;
    sat_julia.const_real      = 32'h7FFF_FFFF;
    sat_julia.const_imag      = 32'h8000_0000;
    long_lim                  = RESET_CFG;
    long_lim.iteration_limit  = 16'hFFFF;

    // reset values: origin is inside the set, far corners escape on step one
    add_case(RESET_CFG, 12'd0,    12'd0,    1'b1, 8'd255);
    add_case(RESET_CFG, 12'hFFF,  12'hFFF,  1'b1, 8'd1);
    add_case(RESET_CFG, 12'hFFF,  12'd0,    1'b1, 8'd1);
    add_case(RESET_CFG, 12'd0,    12'hFFF,  1'b1, 8'd1);
    add_case(RESET_CFG, 12'd1000, 12'd300,  1'b0, 8'd0);
    add_case(RESET_CFG, 12'hAAA,  12'h555,  1'b0, 8'd0);
    add_case(RESET_CFG, 12'h555,  12'hAAA,  1'b0, 8'd0);
    add_case(zero_lim,  12'd0,    12'd0,    1'b1, 8'd0);
    add_case(zero_lim,  12'hFFF,  12'hFFF,  1'b1, 8'd0);
    add_case(zero_step, 12'd0,    12'd0,    1'b1, 8'd44);
    add_case(zero_step, 12'hFFF,  12'hFFF,  1'b1, 8'd44);
    add_case(julia_out, 12'd0,    12'd0,    1'b1, 8'd0);
    add_case(julia_out, 12'hFFF,  12'hFFF,  1'b1, 8'd0);
    add_case(julia_in,  12'd1024, 12'd2048, 1'b0, 8'd0);
    add_case(julia_in,  12'd2000, 12'd2000, 1'b0, 8'd0);
    add_case(sat_mand,  12'd0,    12'd0,    1'b1, 8'd1);
    add_case(sat_mand,  12'hFFF,  12'hFFF,  1'b1, 8'd1);
    add_case(sat_julia, 12'd0,    12'd0,    1'b0, 8'd0);
    add_case(sat_julia, 12'hFFF,  12'd0,    1'b0, 8'd0);
    add_case(long_lim,  12'd0,    12'd0,    1'b1, 8'd255);
    add_case(long_lim,  12'hFFF,  12'hFFF,  1'b1, 8'd1);

    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    verify_regs();

    // directed corners
    foreach (directed[i]) begin
      if (directed[i].new_cfg) begin
        wait_drained();
        program_regs(directed[i].cfg);
      end
      offer_pixel(directed[i].px_col, directed[i].px_row, directed[i].known,
                  directed[i].count);
    end
    n_directed = sent_pixels;

    // random settings, each followed by a burst of random pixels
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      deep     = (ph == 7 || ph == 19);
      n_words  = deep ? DEEP_WORDS : PHASE_WORDS;
      next_cfg = random_setting(deep);
      wait_drained();
      program_regs(next_cfg);
      calm = (ph == 11);
      // sink stalls for a long stretch while pixels keep coming
      if (ph == 4) begin
        hold_req = HOLD_CYCLES;
      end
      repeat (n_words) offer_pixel(random_index(), random_index(), 1'b0, 8'd0);
    end
    calm = 1'b0;

    wait_drained();
    repeat (30) @(posedge clk_i);

    $display("%0d pixels (%0d directed) under %0d register settings plus reset values",
             sent_pixels, n_directed, settings_cnt);
    $display("%0d escape counts compared, %0d mismatches", checked_counts, mismatches);
    if (mismatches == 0) begin
      $display("fractal_escape_time_pixel_unit test passed");
    end else begin
      $display("fractal_escape_time_pixel_unit test failed");
    end
    $finish;
  end

endmodule

[fractal_escape_time_pixel_unit.f]
design/fetp_pkg.sv
design/fetp_front.sv
design/fetp_queue.sv
design/fetp_core.sv
design/fractal_escape_time_pixel_unit.sv
tb/tb_fractal_escape_time_pixel_unit.sv
